// ===== rtl/drpk_pkg.sv =====
// Shared types and constants of the DER RSA public key extractor.
package drpk_pkg;

  localparam int POS_W    = 9;
  localparam int STATUS_W = 3;
  localparam int PAD_W    = 4;

  localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
  localparam logic [7:0] TAG_BIT_STRING = 8'h03;
  localparam logic [7:0] TAG_INTEGER    = 8'h02;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] LEN_LONG_FLAG  = 8'h80;
  localparam logic [7:0] LEN_LONG_MAX   = 8'h84;

  typedef enum logic [4:0] {
    PH_OUTER_TAG, PH_OUTER_LEN, PH_ALGO_TAG, PH_ALGO_LEN, PH_ALGO_SKIP,
    PH_BIT_TAG, PH_BIT_LEN, PH_UNUSED, PH_KEY_TAG, PH_KEY_LEN,
    PH_N_TAG, PH_N_LEN, PH_N_FIRST, PH_N_BODY, PH_E_TAG, PH_E_LEN, PH_E_BODY
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_TAG   = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_BAD_MOD   = 3'd3,
    ST_BAD_EXP   = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  typedef enum logic {
    KIND_KEY    = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // Results caused by one byte: an optional key byte, a run of zero pad
  // bytes at rising positions, then an optional status, in that order.
  typedef struct packed {
    logic             has_key;
    logic [POS_W-1:0] key_pos;
    logic [7:0]       key_val;
    logic [PAD_W-1:0] pad_cnt;
    logic [POS_W-1:0] pad_pos;
    logic             has_stat;
    status_t          stat;
  } job_t;

endpackage

// ===== rtl/der_rsa_pubkey_extractor.sv =====
// Top level of the streaming DER SubjectPublicKeyInfo RSA key extractor.
//
//   channel  direction  ports                                         handshake
//   in       input      in_data_byte, in_last                         in_valid / in_stall
//   out      output     out_kind, out_position, out_key_byte,         out_valid / out_stall
//                       out_status, out_run_last
//
// A byte is parsed in the cycle of its transfer, and while out_stall is low its results
// are issued one per cycle. Most bytes cause at most one result, so one byte per cycle is
// sustained while out_stall is low; a byte that closes the exponent causes up to nine
// results and holds in_stall high until the result sequencer has issued all but the last.
// Reset is synchronous and active low; it returns the parser to the outer tag.
// out_stall holds the output register and, once a job is pending, the input side too.
module der_rsa_pubkey_extractor #(
  parameter int MODULUS_BYTES  = 256,
  parameter int EXPONENT_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [drpk_pkg::POS_W-1:0]    out_position,
  output logic [7:0]                    out_key_byte,
  output logic [drpk_pkg::STATUS_W-1:0] out_status,
  output logic                          out_run_last
);
  import drpk_pkg::*;

  logic accept;
  logic job_valid;
  logic job_ready;
  job_t job;

  assign in_stall = !job_ready;
  assign accept   = in_valid && job_ready;

  drpk_parser #(
    .MODULUS_BYTES  (MODULUS_BYTES),
    .EXPONENT_BYTES (EXPONENT_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last      (in_last),
    .job_valid (job_valid),
    .job       (job)
  );

  drpk_emitter u_emitter (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job_valid),
    .job          (job),
    .job_ready    (job_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_position (out_position),
    .out_key_byte (out_key_byte),
    .out_status   (out_status),
    .out_run_last (out_run_last)
  );

endmodule

// ===== rtl/drpk_parser.sv =====
// Byte-wise DER structure parser that turns each transfer that causes a result into a result job.
module drpk_parser #(
  parameter int MODULUS_BYTES  = 256,
  parameter int EXPONENT_BYTES = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           last,
  output logic           job_valid,
  output drpk_pkg::job_t job
);
  import drpk_pkg::*;

  localparam int MI_W = $clog2(MODULUS_BYTES + 1);
  localparam int EL_W = $clog2(EXPONENT_BYTES + 1);

  phase_t          phase_r, phase_nxt;
  logic [2:0]      lbl_r, lbl_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic [30:0]     cr_r, cr_nxt;
  logic [MI_W-1:0] mi_r, mi_nxt;
  logic [EL_W-1:0] el_r, el_nxt;
  logic [EL_W-1:0] ei_r, ei_nxt;
  logic            fin_r, fin_nxt;

  logic            fail_en;
  status_t         fail_code;
  logic            fin_exp_en;
  logic [EL_W-1:0] fin_exp_len;
  logic            len_done;
  logic [31:0]     len_val;
  logic [31:0]     acc_new;
  logic [31:0]     pos_w;
  logic [31:0]     pad_w;
  logic [EL_W-1:0] ei_inc;

  always_comb begin
    phase_nxt   = phase_r;
    lbl_nxt     = lbl_r;
    acc_nxt     = acc_r;
    cr_nxt      = cr_r;
    mi_nxt      = mi_r;
    el_nxt      = el_r;
    ei_nxt      = ei_r;
    fin_nxt     = fin_r;
    fail_en     = 1'b0;
    fail_code   = ST_OK;
    fin_exp_en  = 1'b0;
    fin_exp_len = el_r;
    len_done    = 1'b0;
    len_val     = 32'd0;
    acc_new     = {acc_r[23:0], data_byte};
    pos_w       = 32'd0;
    pad_w       = 32'd0;
    ei_inc      = ei_r + EL_W'(1);
    job         = '0;
    job.stat    = ST_OK;

    if (!fin_r) begin
      unique case (phase_r)
        PH_OUTER_TAG, PH_ALGO_TAG, PH_KEY_TAG, PH_BIT_TAG, PH_N_TAG, PH_E_TAG: begin
          if (data_byte != ((phase_r == PH_BIT_TAG) ? TAG_BIT_STRING :
                            (phase_r == PH_N_TAG || phase_r == PH_E_TAG) ? TAG_INTEGER :
                            TAG_SEQUENCE)) begin
            fail_en   = 1'b1;
            fail_code = ST_BAD_TAG;
          end else begin
            lbl_nxt = 3'd0;
            acc_nxt = 32'd0;
            unique case (phase_r)
              PH_OUTER_TAG: phase_nxt = PH_OUTER_LEN;
              PH_ALGO_TAG:  phase_nxt = PH_ALGO_LEN;
              PH_BIT_TAG:   phase_nxt = PH_BIT_LEN;
              PH_KEY_TAG:   phase_nxt = PH_KEY_LEN;
              PH_N_TAG:     phase_nxt = PH_N_LEN;
              default:      phase_nxt = PH_E_LEN;
            endcase
          end
        end
        PH_OUTER_LEN, PH_ALGO_LEN, PH_BIT_LEN, PH_KEY_LEN, PH_N_LEN, PH_E_LEN: begin
          if (lbl_r == 3'd0) begin
            if (data_byte < LEN_LONG_FLAG) begin
              len_done = 1'b1;
              len_val  = {24'd0, data_byte};
            end else if (data_byte == LEN_LONG_FLAG || data_byte > LEN_LONG_MAX) begin
              fail_en   = 1'b1;
              fail_code = ST_BAD_LEN;
            end else begin
              lbl_nxt = data_byte[2:0];
              acc_nxt = 32'd0;
            end
          end else begin
            acc_nxt = acc_new;
            lbl_nxt = lbl_r - 3'd1;
            if (lbl_r == 3'd1) begin
              if (acc_new[31]) begin
                fail_en   = 1'b1;
                fail_code = ST_BAD_LEN;
              end else begin
                len_done = 1'b1;
                len_val  = acc_new;
              end
            end
          end
          if (len_done) begin
            unique case (phase_r)
              PH_OUTER_LEN: phase_nxt = PH_ALGO_TAG;
              PH_ALGO_LEN: begin
                if (len_val == 32'd0) begin
                  phase_nxt = PH_BIT_TAG;
                end else begin
                  cr_nxt    = len_val[30:0];
                  phase_nxt = PH_ALGO_SKIP;
                end
              end
              PH_BIT_LEN: phase_nxt = PH_UNUSED;
              PH_KEY_LEN: phase_nxt = PH_N_TAG;
              PH_N_LEN: begin
                if (len_val == 32'(MODULUS_BYTES) || len_val == 32'(MODULUS_BYTES + 1)) begin
                  cr_nxt    = len_val[30:0];
                  mi_nxt    = '0;
                  phase_nxt = PH_N_FIRST;
                end else begin
                  fail_en   = 1'b1;
                  fail_code = ST_BAD_MOD;
                end
              end
              default: begin
                if (len_val > 32'(EXPONENT_BYTES)) begin
                  fail_en   = 1'b1;
                  fail_code = ST_BAD_EXP;
                end else begin
                  el_nxt = len_val[EL_W-1:0];
                  ei_nxt = '0;
                  if (len_val == 32'd0) begin
                    fin_exp_en  = 1'b1;
                    fin_exp_len = '0;
                  end else begin
                    phase_nxt = PH_E_BODY;
                  end
                end
              end
            endcase
          end
        end
        PH_ALGO_SKIP: begin
          cr_nxt = cr_r - 31'd1;
          if (cr_r == 31'd1) begin
            phase_nxt = PH_BIT_TAG;
          end
        end
        PH_UNUSED: begin
          if (data_byte != BYTE_ZERO) begin
            fail_en   = 1'b1;
            fail_code = ST_BAD_TAG;
          end else begin
            phase_nxt = PH_KEY_TAG;
          end
        end
        PH_N_FIRST, PH_N_BODY: begin
          if (phase_r == PH_N_FIRST && cr_r == 31'(MODULUS_BYTES + 1)) begin
            if (data_byte != BYTE_ZERO) begin
              fail_en   = 1'b1;
              fail_code = ST_BAD_MOD;
            end else begin
              cr_nxt    = 31'(MODULUS_BYTES);
              phase_nxt = PH_N_BODY;
            end
          end else if (phase_r == PH_N_FIRST && data_byte == BYTE_ZERO) begin
            fail_en   = 1'b1;
            fail_code = ST_BAD_MOD;
          end else begin
            pos_w       = 32'(MODULUS_BYTES) - 32'd1 - 32'(mi_r);
            job.has_key = 1'b1;
            job.key_pos = pos_w[POS_W-1:0];
            job.key_val = data_byte;
            mi_nxt      = mi_r + MI_W'(1);
            cr_nxt      = cr_r - 31'd1;
            phase_nxt   = (cr_r == 31'd1) ? PH_E_TAG : PH_N_BODY;
          end
        end
        default: begin
          pos_w       = 32'(MODULUS_BYTES) + 32'(el_r) - 32'd1 - 32'(ei_r);
          job.has_key = 1'b1;
          job.key_pos = pos_w[POS_W-1:0];
          job.key_val = data_byte;
          ei_nxt      = ei_inc;
          if (ei_inc >= el_r) begin
            fin_exp_en  = 1'b1;
            fin_exp_len = el_r;
          end
        end
      endcase

      if (fail_en) begin
        job.has_stat = 1'b1;
        job.stat     = fail_code;
      end
      if (fin_exp_en) begin
        pad_w        = 32'(EXPONENT_BYTES) - 32'(fin_exp_len);
        job.pad_cnt  = pad_w[PAD_W-1:0];
        pos_w        = 32'(MODULUS_BYTES) + 32'(fin_exp_len);
        job.pad_pos  = pos_w[POS_W-1:0];
        job.has_stat = 1'b1;
        job.stat     = ST_OK;
      end
      fin_nxt = fail_en | fin_exp_en;
      if (last && !fin_nxt) begin
        job.has_stat = 1'b1;
        job.stat     = ST_TRUNCATED;
        fin_nxt      = 1'b1;
      end
    end

    if (last) begin
      phase_nxt = PH_OUTER_TAG;
      lbl_nxt   = 3'd0;
      acc_nxt   = 32'd0;
      cr_nxt    = 31'd0;
      mi_nxt    = '0;
      el_nxt    = '0;
      ei_nxt    = '0;
      fin_nxt   = 1'b0;
    end

    job_valid = accept && (job.has_key || job.pad_cnt != '0 || job.has_stat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OUTER_TAG;
      lbl_r   <= 3'd0;
      acc_r   <= 32'd0;
      cr_r    <= 31'd0;
      mi_r    <= '0;
      el_r    <= '0;
      ei_r    <= '0;
      fin_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      lbl_r   <= lbl_nxt;
      acc_r   <= acc_nxt;
      cr_r    <= cr_nxt;
      mi_r    <= mi_nxt;
      el_r    <= el_nxt;
      ei_r    <= ei_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// ===== rtl/drpk_emitter.sv =====
// Result sequencer that issues a job's results into the output register, one per cycle unless stalled.
module drpk_emitter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  input  drpk_pkg::job_t               job,
  output logic                         job_ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_kind,
  output logic [drpk_pkg::POS_W-1:0]   out_position,
  output logic [7:0]                   out_key_byte,
  output logic [drpk_pkg::STATUS_W-1:0] out_status,
  output logic                         out_run_last
);
  import drpk_pkg::*;

  job_t             job_r, job_nxt;
  logic             busy;
  logic             is_final;
  logic             out_load;

  logic             out_valid_r, out_valid_nxt;
  kind_t            kind_r, kind_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       byte_r, byte_nxt;
  status_t          stat_r, stat_nxt;
  logic             run_last_r, run_last_nxt;

  always_comb begin
    busy     = job_r.has_key || job_r.pad_cnt != '0 || job_r.has_stat;
    is_final = job_r.has_key ? (job_r.pad_cnt == '0 && !job_r.has_stat)
             : (job_r.pad_cnt == '0 || (job_r.pad_cnt == PAD_W'(1) && !job_r.has_stat));
    out_load  = busy && (!out_valid_r || !out_stall);
    job_ready = !busy || (is_final && out_load);

    kind_nxt     = kind_r;
    pos_nxt      = pos_r;
    byte_nxt     = byte_r;
    stat_nxt     = stat_r;
    run_last_nxt = run_last_r;
    job_nxt      = job_r;
    if (out_load) begin
      run_last_nxt = is_final;
      if (job_r.has_key) begin
        kind_nxt        = KIND_KEY;
        pos_nxt         = job_r.key_pos;
        byte_nxt        = job_r.key_val;
        stat_nxt        = ST_OK;
        job_nxt.has_key = 1'b0;
      end else if (job_r.pad_cnt != '0) begin
        kind_nxt        = KIND_KEY;
        pos_nxt         = job_r.pad_pos;
        byte_nxt        = 8'd0;
        stat_nxt        = ST_OK;
        job_nxt.pad_pos = job_r.pad_pos + POS_W'(1);
        job_nxt.pad_cnt = job_r.pad_cnt - PAD_W'(1);
      end else begin
        kind_nxt         = KIND_STATUS;
        pos_nxt          = '0;
        byte_nxt         = 8'd0;
        stat_nxt         = job_r.stat;
        job_nxt.has_stat = 1'b0;
      end
    end
    if (job_valid && job_ready) begin
      job_nxt = job;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    job_r.key_pos <= job_nxt.key_pos;
    job_r.key_val <= job_nxt.key_val;
    job_r.pad_pos <= job_nxt.pad_pos;
    job_r.stat    <= job_nxt.stat;
    if (!rst_n) begin
      job_r.has_key  <= 1'b0;
      job_r.pad_cnt  <= '0;
      job_r.has_stat <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      job_r.has_key  <= job_nxt.has_key;
      job_r.pad_cnt  <= job_nxt.pad_cnt;
      job_r.has_stat <= job_nxt.has_stat;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    pos_r         <= pos_nxt;
    byte_r        <= byte_nxt;
    stat_r        <= stat_nxt;
    run_last_r    <= run_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = kind_r;
  assign out_position = pos_r;
  assign out_key_byte = byte_r;
  assign out_status   = stat_r;
  assign out_run_last = run_last_r;

  a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_STATUS) |-> run_last_r)
    else $error("status result without run_last");

  a_key_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_KEY) |-> (stat_r == ST_OK))
    else $error("key byte result carries a nonzero status");

  a_pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_r.pad_cnt <= PAD_W'(8))
    else $error("pad count exceeds exponent width");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !out_load) |=> busy)
    else $error("pending job lost without a transfer");

endmodule
